// ===== design/lzwc_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types, constants and helpers of the LZW compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

	localparam int DICT_ENTRIES_DEFAULT = 32768;
	localparam int QUEUE_DEPTH = 4;
	localparam int EPOCH_W = 8;
	localparam int CFG_ADDR_W = 3;

	localparam logic [15:0] FIRST_FREE_CODE = 16'd257;
	localparam logic [15:0] END_CODE = 16'd256;
	localparam logic [4:0] MIN_WIDTH = 5'd9;
	localparam logic [3:0] RESET_WIDTH_DEFAULT = 4'd12;
	localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

	// configuration register index
	localparam logic REG_RESET_WIDTH = 1'b0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last;
		logic first;
	} item_t;

	typedef enum logic [1:0] {
		PK_CODE,
		PK_HEADER,
		PK_FLUSH
	} pk_kind_t;

	typedef struct packed {
		pk_kind_t kind;
		logic [15:0] value;
		logic [4:0] width;
	} pk_req_t;

	typedef struct packed {
		logic clearing;
	} eng_status_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [23:0] key;
		logic [15:0] code;
	} dict_word_t;

	// code width needed for a code value: 9 below 512, at most 16
	function automatic logic [4:0] width_for(input logic [15:0] code);
		logic [4:0] w;
		w = MIN_WIDTH;
		for (int i = 9; i < 16; i++) begin
			if (code >= (16'd1 << i))
				w = 5'(i + 1);
		end
		return w;
	endfunction

endpackage

// ===== design/lzwc_ifs.sv =====
// ----------------------------------------------------------------------------
// lzwc stream interfaces
// Byte input channel and packed byte output channel.
// ----------------------------------------------------------------------------
interface lzwc_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface lzwc_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_out;

	modport source (output valid, output out_byte, output last_out, input ready);
	modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

// ===== design/lzwc_front.sv =====
// ----------------------------------------------------------------------------
// lzwc_front
// Accepts input bytes, marks the first byte of each stream, and queues them.
// ----------------------------------------------------------------------------
module lzwc_front (
	input logic clk,
	input logic arst_n,
	lzwc_in_if.sink plain,
	input lzwc_pkg::eng_status_t status,
	output logic item_valid,
	output lzwc_pkg::item_t item,
	input logic item_ready
);

	localparam int QA = $clog2(lzwc_pkg::QUEUE_DEPTH);

	lzwc_pkg::item_t queue_q [lzwc_pkg::QUEUE_DEPTH];
	logic [QA-1:0] wr_ptr_q;
	logic [QA-1:0] rd_ptr_q;
	logic [QA:0] count_q;
	logic first_q;
	logic push;
	logic pop;

	assign plain.ready = (count_q != (QA+1)'(lzwc_pkg::QUEUE_DEPTH)) && !status.clearing;
	assign push = plain.valid && plain.ready;
	assign item_valid = (count_q != '0);
	assign item = queue_q[rd_ptr_q];
	assign pop = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{data_byte: plain.data_byte, last: plain.end_of_data,
				first: first_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				// a new stream starts after the final byte
				first_q <= plain.end_of_data;
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== design/lzwc_engine.sv =====
// ----------------------------------------------------------------------------
// lzwc_engine
// Dictionary lookup by hashing and linear probing, code sequencing and
// dictionary clearing by epoch marks.
// ----------------------------------------------------------------------------
module lzwc_engine #(
	parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic [3:0] reset_width,
	input logic item_valid,
	input lzwc_pkg::item_t item,
	output logic item_ready,
	output logic req_valid,
	output lzwc_pkg::pk_req_t req,
	input logic req_ready,
	output lzwc_pkg::eng_status_t status
);

	localparam int AW = $clog2(DICT_ENTRIES);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DICT_ENTRIES - 1);
	localparam logic [23:0] RECIP = 24'((64'd1 << 32) / DICT_ENTRIES);
	localparam logic [16:0] N_C = 17'(DICT_ENTRIES);
	localparam logic [lzwc_pkg::EPOCH_W-1:0] EPOCH_LAST = '1;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HEADER,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_H4,
		ST_RD,
		ST_CMP,
		ST_MISS,
		ST_END_PREFIX,
		ST_END_CODE,
		ST_FLUSH
	} state_t;

	state_t state_q;
	state_t after_q;
	state_t nxt_item;

	lzwc_pkg::dict_word_t mem [DICT_ENTRIES];
	lzwc_pkg::dict_word_t rd_q;
	lzwc_pkg::dict_word_t wr_data;
	logic [AW-1:0] wr_addr;
	logic wr_en;

	logic [7:0] byte_q;
	logic last_q;
	logic [23:0] key_q;
	logic [15:0] prefix_q;
	logic [15:0] next_code_q;
	logic [4:0] code_width_q;
	logic [lzwc_pkg::EPOCH_W-1:0] epoch_q;
	logic [AW-1:0] sweep_idx_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] probe_cnt_q;
	logic slot_ok_q;

	logic [31:0] hp_s1;
	logic [47:0] hm_s2;
	logic [23:0] hh_s2;
	logic [23:0] hqn_s3;
	logic [23:0] hh_s3;
	logic [23:0] rem;

	logic [4:0] w_next;
	logic too_wide;

	assign w_next = lzwc_pkg::width_for(next_code_q);
	assign too_wide = w_next > {1'b0, reset_width};
	assign nxt_item = last_q ? ST_END_PREFIX : ST_IDLE;
	assign rem = hh_s3 - hqn_s3;
	assign item_ready = (state_q == ST_IDLE);
	assign status.clearing = (state_q == ST_SWEEP);

	always_comb begin
		req_valid = 1'b0;
		req.kind = lzwc_pkg::PK_CODE;
		req.value = prefix_q;
		req.width = code_width_q;
		unique case (state_q)
			ST_HEADER: begin
				req_valid = 1'b1;
				req.kind = lzwc_pkg::PK_HEADER;
				req.value = {12'd0, reset_width};
			end
			ST_MISS, ST_END_PREFIX: begin
				req_valid = 1'b1;
			end
			ST_END_CODE: begin
				req_valid = 1'b1;
				req.value = lzwc_pkg::END_CODE;
			end
			ST_FLUSH: begin
				req_valid = 1'b1;
				req.kind = lzwc_pkg::PK_FLUSH;
				req.value = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = slot_q;
		wr_data = '{epoch: epoch_q, key: key_q, code: next_code_q};
		if (state_q == ST_SWEEP) begin
			wr_en = 1'b1;
			wr_addr = sweep_idx_q;
			wr_data = '0;
		end else if (state_q == ST_MISS && req_ready && !too_wide && slot_ok_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (state_q == ST_RD)
			rd_q <= mem[slot_q];
	end

	// hash pipeline: multiply, reciprocal multiply, back-multiply, correct
	always_ff @(posedge clk) begin
		hp_s1 <= 32'({8'd0, key_q} * lzwc_pkg::HASH_MULT);
		hh_s2 <= hp_s1[31:8];
		hm_s2 <= hp_s1[31:8] * RECIP;
		hh_s3 <= hh_s2;
		hqn_s3 <= 24'(hm_s2[47:32] * N_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			after_q <= ST_IDLE;
			sweep_idx_q <= '0;
			epoch_q <= {{(lzwc_pkg::EPOCH_W-1){1'b0}}, 1'b1};
			next_code_q <= lzwc_pkg::FIRST_FREE_CODE;
			code_width_q <= lzwc_pkg::MIN_WIDTH;
			prefix_q <= '0;
			byte_q <= '0;
			last_q <= 1'b0;
			key_q <= '0;
			slot_q <= '0;
			probe_cnt_q <= '0;
			slot_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					if (sweep_idx_q == LAST_SLOT)
						state_q <= after_q;
					else
						sweep_idx_q <= sweep_idx_q + 1'b1;
				end
				ST_IDLE: begin
					if (item_valid) begin
						byte_q <= item.data_byte;
						last_q <= item.last;
						key_q <= {prefix_q, item.data_byte};
						state_q <= item.first ? ST_HEADER : ST_H1;
					end
				end
				ST_HEADER: begin
					if (req_ready) begin
						prefix_q <= {8'd0, byte_q};
						state_q <= nxt_item;
					end
				end
				ST_H1: state_q <= ST_H2;
				ST_H2: state_q <= ST_H3;
				ST_H3: state_q <= ST_H4;
				ST_H4: begin
					slot_q <= AW'((rem >= {7'd0, N_C}) ? rem - {7'd0, N_C} : rem);
					probe_cnt_q <= '0;
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					priority if (rd_q.epoch != epoch_q) begin
						slot_ok_q <= 1'b1;
						state_q <= ST_MISS;
					end else if (rd_q.key == key_q) begin
						prefix_q <= rd_q.code;
						state_q <= nxt_item;
					end else if (probe_cnt_q == LAST_SLOT) begin
						// every slot taken: drop the new pair
						slot_ok_q <= 1'b0;
						state_q <= ST_MISS;
					end else begin
						probe_cnt_q <= probe_cnt_q + 1'b1;
						slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_MISS: begin
					if (req_ready) begin
						prefix_q <= {8'd0, byte_q};
						if (too_wide) begin
							next_code_q <= lzwc_pkg::FIRST_FREE_CODE;
							code_width_q <= lzwc_pkg::MIN_WIDTH;
							if (epoch_q == EPOCH_LAST) begin
								epoch_q <= {{(lzwc_pkg::EPOCH_W-1){1'b0}}, 1'b1};
								sweep_idx_q <= '0;
								after_q <= nxt_item;
								state_q <= ST_SWEEP;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= nxt_item;
							end
						end else begin
							code_width_q <= w_next;
							next_code_q <= next_code_q + 1'b1;
							state_q <= nxt_item;
						end
					end
				end
				ST_END_PREFIX: begin
					if (req_ready) begin
						code_width_q <= too_wide ? lzwc_pkg::MIN_WIDTH : w_next;
						state_q <= ST_END_CODE;
					end
				end
				ST_END_CODE: begin
					if (req_ready)
						state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (req_ready) begin
						prefix_q <= '0;
						next_code_q <= lzwc_pkg::FIRST_FREE_CODE;
						code_width_q <= lzwc_pkg::MIN_WIDTH;
						if (epoch_q == EPOCH_LAST) begin
							epoch_q <= {{(lzwc_pkg::EPOCH_W-1){1'b0}}, 1'b1};
							sweep_idx_q <= '0;
							after_q <= ST_IDLE;
							state_q <= ST_SWEEP;
						end else begin
							epoch_q <= epoch_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/lzwc_packer.sv =====
// ----------------------------------------------------------------------------
// lzwc_packer
// Packs variable-width codes MSB first into bytes behind an output register.
// ----------------------------------------------------------------------------
module lzwc_packer (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input lzwc_pkg::pk_req_t req,
	output logic req_ready,
	lzwc_out_if.source coded
);

	logic [23:0] buf_q;
	logic [4:0] cnt_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_last_q;

	logic slot_free;
	logic emit;
	logic take;
	logic [15:0] code_mask;
	logic [39:0] grown;
	logic [4:0] left;
	logic [7:0] emit_byte;
	logic [23:0] kept;
	logic [7:0] pad_byte;

	assign coded.valid = out_valid_q;
	assign coded.out_byte = out_byte_q;
	assign coded.last_out = out_last_q;

	always_comb begin
		slot_free = !out_valid_q || coded.ready;
		emit = (cnt_q > 5'd8) && slot_free;
		req_ready = (cnt_q <= 5'd8) && ((req.kind == lzwc_pkg::PK_CODE) || slot_free);
		take = req_valid && req_ready;
		code_mask = 16'((17'd1 << req.width) - 17'd1);
		grown = ({16'd0, buf_q} << req.width) | {24'd0, req.value & code_mask};
		left = cnt_q - 5'd8;
		emit_byte = 8'(buf_q >> left);
		kept = buf_q & ((24'd1 << left) - 24'd1);
		pad_byte = 8'(buf_q << (5'd8 - cnt_q));
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= 1'b0;
		end else if (take && req.kind == lzwc_pkg::PK_HEADER) begin
			out_byte_q <= req.value[7:0];
			out_last_q <= 1'b0;
		end else if (take && req.kind == lzwc_pkg::PK_FLUSH) begin
			// pad the leftover bits with zeros at the low end
			out_byte_q <= pad_byte;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				buf_q <= kept;
				cnt_q <= left;
				out_valid_q <= 1'b1;
			end else if (take) begin
				unique case (req.kind)
					lzwc_pkg::PK_CODE: begin
						buf_q <= grown[23:0];
						cnt_q <= cnt_q + req.width;
						if (coded.ready)
							out_valid_q <= 1'b0;
					end
					lzwc_pkg::PK_HEADER: out_valid_q <= 1'b1;
					lzwc_pkg::PK_FLUSH: begin
						buf_q <= '0;
						cnt_q <= '0;
						out_valid_q <= 1'b1;
					end
					default: begin
						if (coded.ready)
							out_valid_q <= 1'b0;
					end
				endcase
			end else if (coded.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/lzw_compressor_with_reset_top.sv =====
// ----------------------------------------------------------------------------
// lzw_compressor_with_reset_top
// LZW compressor with variable code width and dictionary reset.
//
// Channels: plain takes one byte per request with end_of_data on the final
// byte of a stream; coded delivers the packed stream MSB first, one byte per
// request, last_out on the padded final byte. Each stream opens with a
// header byte holding reset_width. reset_width is written over the APB port.
// Engine: a stream's first byte passes the header state; any other byte
// passes hash states H1 to H4, a registered dictionary read and a compare,
// then a miss state when a new code goes out, plus a read and compare per
// extra probe. The engine takes a new byte only when idle. End of a stream
// adds 3 packer requests. A 4-entry queue keeps the input side taking bytes
// while the engine works; an output register decouples the coded side.
// Reset: a clearing pass over all DICT_ENTRIES entries marks each one
// stale; plain.ready stays low during it. The same pass runs once every 255
// dictionary clears, when the epoch mark wraps.
// Stall: when coded.ready is low, the packer and then the engine hold.
// ----------------------------------------------------------------------------
module lzw_compressor_with_reset_top #(
	parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	lzwc_in_if.sink plain,
	lzwc_out_if.source coded,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [lzwc_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [3:0] reset_width_q;
	logic item_valid;
	lzwc_pkg::item_t item;
	logic item_ready;
	logic req_valid;
	lzwc_pkg::pk_req_t req;
	logic req_ready;
	lzwc_pkg::eng_status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == lzwc_pkg::REG_RESET_WIDTH) ? {28'd0, reset_width_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			reset_width_q <= lzwc_pkg::RESET_WIDTH_DEFAULT;
		else if (psel && penable && pwrite && pready && paddr[2] == lzwc_pkg::REG_RESET_WIDTH)
			reset_width_q <= pwdata[3:0];
	end

	lzwc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.plain(plain),
		.status(status),
		.item_valid(item_valid),
		.item(item),
		.item_ready(item_ready)
	);

	lzwc_engine #(
		.DICT_ENTRIES(DICT_ENTRIES)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.reset_width(reset_width_q),
		.item_valid(item_valid),
		.item(item),
		.item_ready(item_ready),
		.req_valid(req_valid),
		.req(req),
		.req_ready(req_ready),
		.status(status)
	);

	lzwc_packer u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_ready(req_ready),
		.coded(coded)
	);

endmodule

// ===== design/lzwc_checker.sv =====
// ----------------------------------------------------------------------------
// lzwc_checker
// Port-level checks of the LZW compressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzwc_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] out_byte,
	input logic out_last,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic pready
);

	// hold a stalled output byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output byte changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// a register write shows on the read data in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && !paddr[2]
		|=> paddr[2] || prdata[3:0] == $past(pwdata[3:0]))
		else $error("reset_width readback mismatch");

	assert property (@(posedge clk) disable iff (!arst_n) prdata[31:4] == 28'd0)
		else $error("unused read data bits set");

endmodule

bind lzw_compressor_with_reset_top lzwc_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(coded.valid),
	.out_ready(coded.ready),
	.out_byte(coded.out_byte),
	.out_last(coded.last_out),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata),
	.pready(pready)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Streams of bytes go into the LZW compressor and the packed output is
// compared byte by byte with a scoreboard that models the dictionary, the
// code widths, the clears and the bit packing. Both channels idle at random.
// The reset width is changed between phases, and once in the middle of a
// stream.
// ----------------------------------------------------------------------------
module tb;

	localparam int TABLE_SLOTS = lzwc_pkg::DICT_ENTRIES_DEFAULT;

	class lzw_scoreboard;
		typedef struct {
			logic [7:0] out_byte;
			logic last_out;
		} packed_byte_t;

		packed_byte_t stream_q[$];
		int slot_epoch[];
		logic [23:0] slot_key[];
		logic [15:0] slot_code[];
		int epoch;
		logic [3:0] clear_width;
		logic [15:0] prefix;
		bit have_prefix;
		int unsigned next_code;
		int unsigned code_bits;
		int unsigned bit_buf;
		int unsigned bit_cnt;
		bit header_done;
		int mismatches;
		int bytes_checked;

		function new();
			slot_epoch = new[TABLE_SLOTS];
			slot_key = new[TABLE_SLOTS];
			slot_code = new[TABLE_SLOTS];
			epoch = 1;
			clear_width = lzwc_pkg::RESET_WIDTH_DEFAULT;
			mismatches = 0;
			bytes_checked = 0;
			restart();
		endfunction

		function void clear_table();
			epoch++;
			next_code = 32'(lzwc_pkg::FIRST_FREE_CODE);
			code_bits = 32'(lzwc_pkg::MIN_WIDTH);
		endfunction

		function void restart();
			clear_table();
			prefix = '0;
			have_prefix = 0;
			bit_buf = 0;
			bit_cnt = 0;
			header_done = 0;
		endfunction

		function int unsigned bits_needed(int unsigned code);
			int unsigned w;
			w = 9;
			while (w < 16 && code >= (32'd1 << w))
				w++;
			return w;
		endfunction

		function int home_slot(logic [23:0] key);
			logic [31:0] h;
			h = 32'(key) * lzwc_pkg::HASH_MULT;
			return int'((h >> 8) % TABLE_SLOTS);
		endfunction

		function bit lookup(logic [23:0] key, output logic [15:0] code);
			int s;
			s = home_slot(key);
			code = '0;
			for (int n = 0; n < TABLE_SLOTS; n++) begin
				if (slot_epoch[s] != epoch)
					return 0;
				if (slot_key[s] == key) begin
					code = slot_code[s];
					return 1;
				end
				s = (s + 1) % TABLE_SLOTS;
			end
			return 0;
		endfunction

		function void store(logic [23:0] key, logic [15:0] code);
			int s;
			s = home_slot(key);
			for (int n = 0; n < TABLE_SLOTS; n++) begin
				if (slot_epoch[s] != epoch) begin
					slot_epoch[s] = epoch;
					slot_key[s] = key;
					slot_code[s] = code;
					return;
				end
				s = (s + 1) % TABLE_SLOTS;
			end
		endfunction

		function void push_byte(int unsigned b);
			packed_byte_t e;
			e.out_byte = b[7:0];
			e.last_out = 0;
			stream_q.push_back(e);
		endfunction

		function void pack_code(int unsigned code);
			bit_buf = ((bit_buf << code_bits) | (code & ((32'd1 << code_bits) - 1)))
				& 32'hFF_FFFF;
			bit_cnt += code_bits;
			while (bit_cnt > 8) begin
				push_byte(bit_buf >> (bit_cnt - 8));
				bit_cnt -= 8;
				bit_buf &= (32'd1 << bit_cnt) - 1;
			end
		endfunction

		// returns 1 when the dictionary had to be cleared
		function bit widen();
			code_bits = bits_needed(next_code);
			if (code_bits > clear_width) begin
				clear_table();
				return 1;
			end
			return 0;
		endfunction

		function void note_request(logic [7:0] b, logic eod);
			logic [23:0] key;
			logic [15:0] hit;
			if (!header_done) begin
				push_byte(32'(clear_width));
				header_done = 1;
			end
			if (!have_prefix) begin
				prefix = {8'd0, b};
				have_prefix = 1;
			end else begin
				key = {prefix, b};
				if (lookup(key, hit))
					prefix = hit;
				else begin
					pack_code(32'(prefix));
					if (!widen()) begin
						store(key, next_code[15:0]);
						next_code = (next_code + 1) & 32'hFFFF;
					end
					prefix = {8'd0, b};
				end
			end
			if (eod) begin
				pack_code(32'(prefix));
				void'(widen());
				pack_code(32'(lzwc_pkg::END_CODE));
				if (bit_cnt != 0)
					push_byte(bit_buf << (8 - bit_cnt));
				stream_q[stream_q.size() - 1].last_out = 1;
				restart();
			end
		endfunction

		task report(string what);
			mismatches++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_byte(logic [7:0] b, logic l);
			packed_byte_t e;
			bytes_checked++;
			if (stream_q.size() == 0) begin
				report($sformatf("unexpected byte %02h last %0b", b, l));
				return;
			end
			e = stream_q.pop_front();
			if (b !== e.out_byte)
				report($sformatf("out_byte %02h, want %02h", b, e.out_byte));
			if (l !== e.last_out)
				report($sformatf("last_out %0b, want %0b", l, e.last_out));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [lzwc_pkg::CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	lzwc_in_if plain_if();
	lzwc_out_if coded_if();

	lzw_compressor_with_reset_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.plain(plain_if),
		.coded(coded_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	lzw_scoreboard sb = new();
	bit idle_on = 1;
	bit hold_req = 0;
	int bytes_sent = 0;
	int streams_sent = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// output side: check, then pick next ready
	always begin : coded_sink
		int stall_left;
		stall_left = 0;
		coded_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (coded_if.valid && coded_if.ready)
				sb.check_byte(coded_if.out_byte, coded_if.last_out);
			if (hold_req) begin
				hold_req = 0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				coded_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				coded_if.ready <= 1'b0;
			end else
				coded_if.ready <= 1'b1;
		end
	end

	// valid stays high after an accept until the next request or a drain
	task send_request(logic [7:0] b, logic eod);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			plain_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		plain_if.valid <= 1'b1;
		plain_if.data_byte <= b;
		plain_if.end_of_data <= eod;
		do
			@(posedge clk);
		while (!plain_if.ready);
		sb.note_request(b, eod);
		bytes_sent++;
		if (eod)
			streams_sent++;
	endtask

	task send_seq(logic [7:0] q[$], bit close);
		foreach (q[i])
			send_request(q[i], close && i == q.size() - 1);
	endtask

	// hold until the block has nothing left to say, then let it settle
	task drain();
		plain_if.valid <= 1'b0;
		while (sb.stream_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task write_reset_width(logic [3:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= lzwc_pkg::CFG_ADDR_W'(lzwc_pkg::REG_RESET_WIDTH) << 2;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.clear_width = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function logic [7:0] pick_byte(bit wide);
		if (wide || $urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(65, 68));
	endfunction

	task random_streams(int budget, bit wide);
		int len;
		while (budget > 0) begin
			len = $urandom_range(1, 10);
			if (len > budget)
				len = budget;
			for (int i = 0; i < len; i++)
				send_request(pick_byte(wide), i == len - 1);
			budget -= len;
		end
	endtask

	initial begin : stimulus
		logic [3:0] widths[6];
		widths = '{4'd15, 4'd13, 4'd10, 4'd11, 4'd14, 4'd12};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		plain_if.valid <= 1'b0;
		plain_if.data_byte <= '0;
		plain_if.end_of_data <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte streams, a run and an alternating pattern at the default width
		send_seq('{8'h00}, 1);
		send_seq('{8'hFF}, 1);
		send_seq('{8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h42}, 1);
		send_seq('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1);
		// width changed mid-stream: header keeps the old value
		send_seq('{8'h41, 8'h42, 8'h41, 8'h42}, 0);
		drain();
		write_reset_width(4'd9);
		send_seq('{8'h41, 8'h42, 8'h43}, 1);
		// below nine every new pair clears
		drain();
		write_reset_width(4'd8);
		send_seq('{8'h01, 8'h01, 8'h01, 8'h02, 8'h02}, 1);

		// one long stream at width nine so the dictionary fills and clears;
		// the output side holds off at the start so the input backs up
		drain();
		write_reset_width(4'd9);
		hold_req = 1;
		for (int i = 0; i < 270; i++)
			send_request(pick_byte(1), i == 269);

		foreach (widths[k]) begin
			drain();
			if (k == 5)
				idle_on = 0;
			write_reset_width(widths[k]);
			random_streams(12, 0);
		end

		drain();
		if (sb.stream_q.size() != 0)
			sb.report($sformatf("%0d bytes never came", sb.stream_q.size()));
		$display("sent %0d bytes in %0d streams, checked %0d packed bytes",
			bytes_sent, streams_sent, sb.bytes_checked);
		$display("reset widths 8 to 15, mid-stream change, dictionary clears, stalls");
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== lzw_compressor_with_reset_top.f =====
design/lzwc_pkg.sv
design/lzwc_ifs.sv
design/lzwc_front.sv
design/lzwc_engine.sv
design/lzwc_packer.sv
design/lzw_compressor_with_reset_top.sv
design/lzwc_checker.sv
tb/tb.sv
